@@ rtl/core/cfsp_pkg.sv @@
// shared constants for the cube face to sphere point mapper
// no dependencies; used by the top level and its port checker
package cfsp_pkg;

    localparam int unsigned FIELD_W = 18;
    localparam int unsigned N_AXES  = 3;

    typedef enum logic [2:0] {
        FACE_TOP    = 3'd0,
        FACE_BOTTOM = 3'd1,
        FACE_RIGHT  = 3'd2,
        FACE_LEFT   = 3'd3,
        FACE_BACK   = 3'd4,
        FACE_FRONT  = 3'd5,
        FACE_BAD6   = 3'd6,
        FACE_BAD7   = 3'd7
    } t_face;

endpackage

@@ rtl/core/cube_face_to_sphere_point.sv @@
// cube face to sphere point mapper, fully pipelined
// depends on cfsp_pkg; port checker bound in cfsp_checker.sv
//
// Usage: the input channel (i_valid/o_ready) carries a face code and the
// Q2.F face coordinates u and v. The output channel (o_valid/i_ready)
// carries the sphere point x, y, z in Q2.F and a bad_input flag. A face
// code of 6 or 7, or u or v outside +-1, gives bad_input high and zero
// coordinates.
// The pipeline registers face decode, squares, pair products, divide by
// three and radicand, then the pipelined square root, which forms one
// result bit per stage (FRAC_BITS + 1 of them), and a final scaling
// multiply into the output register.
// Throughput is one transaction per cycle while the receiver does not stall;
// each of the three axes has its own multipliers and root pipeline.
// Reset (synchronous, active low) clears every stage valid bit; data
// registers are not reset.
// When the receiver stalls, the whole pipeline holds and o_ready drops
// in the same cycle, so nothing is lost or repeated.
module cube_face_to_sphere_point #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [2:0]                          i_face,
    input  logic signed [cfsp_pkg::FIELD_W-1:0] i_u_coord,
    input  logic signed [cfsp_pkg::FIELD_W-1:0] i_v_coord,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [cfsp_pkg::FIELD_W-1:0] o_sphere_x,
    output logic signed [cfsp_pkg::FIELD_W-1:0] o_sphere_y,
    output logic signed [cfsp_pkg::FIELD_W-1:0] o_sphere_z,
    output logic                                o_bad_input
);
    import cfsp_pkg::*;

    localparam int unsigned NW    = FRAC_BITS + 1;     // magnitude / root width
    localparam int unsigned NS    = FRAC_BITS + 1;     // root stages
    localparam int unsigned RW    = FRAC_BITS + 3;     // root remainder width
    localparam int unsigned KSH   = FRAC_BITS + 3;     // divide-by-3 shift
    localparam int unsigned MW    = FRAC_BITS + 2;
    localparam logic [MW-1:0] MUL3 =
        MW'(((64'd1 << KSH) + 64'd2) / 64'd3);
    localparam logic [NW-1:0] ONE_M = NW'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic [N_AXES-1:0][NW-1:0] mag;
        logic [N_AXES-1:0]         neg;
        logic                      bad;
    } t_side;

    logic adv;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // stage a: face decode, range check, sign and magnitude
    logic signed [31:0] u_w, v_w, one_w;
    logic [NW-1:0]      u_m, v_m;
    logic               u_n, v_n;
    t_side              n_a;

    always_comb begin
        one_w = 32'sd1 <<< FRAC_BITS;
        u_w   = 32'(i_u_coord);
        v_w   = 32'(i_v_coord);
        u_m   = NW'(u_w < 0 ? -u_w : u_w);
        v_m   = NW'(v_w < 0 ? -v_w : v_w);
        u_n   = u_w < 0;
        v_n   = v_w < 0;
        n_a.bad = (i_face > 3'(FACE_FRONT)) || (u_w > one_w) || (u_w < -one_w)
                  || (v_w > one_w) || (v_w < -one_w);
        n_a.mag = '0;
        n_a.neg = '0;
        unique case (t_face'(i_face))
            FACE_TOP: begin
                n_a.mag = {ONE_M, v_m, u_m};
                n_a.neg = {1'b0, v_n, u_n};
            end
            FACE_BOTTOM: begin
                n_a.mag = {ONE_M, v_m, u_m};
                n_a.neg = {1'b1, v_n, !u_n};
            end
            FACE_RIGHT: begin
                n_a.mag = {u_m, v_m, ONE_M};
                n_a.neg = {!u_n, v_n, 1'b0};
            end
            FACE_LEFT: begin
                n_a.mag = {u_m, v_m, ONE_M};
                n_a.neg = {u_n, v_n, 1'b1};
            end
            FACE_BACK: begin
                n_a.mag = {v_m, ONE_M, u_m};
                n_a.neg = {v_n, 1'b1, u_n};
            end
            FACE_FRONT: begin
                n_a.mag = {v_m, ONE_M, u_m};
                n_a.neg = {!v_n, 1'b0, u_n};
            end
            default: begin
                n_a.mag = '0;
                n_a.neg = '0;
            end
        endcase
    end

    t_side r_a, r_b, r_c, r_d, r_e;
    logic  r_vld_a, r_vld_b, r_vld_c, r_vld_d, r_vld_e;

    logic [N_AXES-1:0][NW-1:0] r_sq;      // stage b
    logic [N_AXES-1:0][NW-1:0] r_pp;      // stage c
    logic [N_AXES-1:0][NW:0]   r_hs;      // stage c
    logic [N_AXES-1:0][NW-1:0] r_d3;      // stage d
    logic [N_AXES-1:0][NW:0]   r_hs_d;    // stage d
    logic [N_AXES-1:0][NW-1:0] r_rad;     // stage e

    logic [N_AXES-1:0][NW-1:0] n_sq, n_pp, n_d3, n_rad;
    logic [N_AXES-1:0][NW:0]   n_hs;

    always_comb begin
        for (int k = 0; k < N_AXES; k++) begin
            logic [2*NW-1:0]     prod;
            logic [2*NW-1:0]     pprod;
            logic [NW+MW-1:0]    dprod;
            logic signed [NW+2:0] rad;
            prod     = r_a.mag[k] * r_a.mag[k];
            n_sq[k]  = NW'(prod >> FRAC_BITS);
            pprod    = r_sq[(k+1)%3] * r_sq[(k+2)%3];
            n_pp[k]  = NW'(pprod >> FRAC_BITS);
            n_hs[k]  = (NW+1)'(r_sq[(k+1)%3] >> 1) + (NW+1)'(r_sq[(k+2)%3] >> 1);
            dprod    = r_pp[k] * MUL3;
            n_d3[k]  = NW'(dprod >> KSH);
            rad      = $signed((NW+3)'(ONE_M)) - $signed((NW+3)'(r_hs_d[k]))
                       + $signed((NW+3)'(r_d3[k]));
            n_rad[k] = (rad < 0) ? '0 : NW'(rad);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
            r_vld_e <= 1'b0;
        end else if (adv) begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
            r_vld_d <= r_vld_c;
            r_vld_e <= r_vld_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a    <= n_a;
            r_b    <= r_a;
            r_sq   <= n_sq;
            r_c    <= r_b;
            r_pp   <= n_pp;
            r_hs   <= n_hs;
            r_d    <= r_c;
            r_d3   <= n_d3;
            r_hs_d <= r_hs;
            r_e    <= r_d;
            r_rad  <= n_rad;
        end
    end

    // square root pipeline, two radicand bits per stage
    t_side                       r_rt_side [1:NS];
    logic                        r_rt_vld  [1:NS];
    logic [N_AXES-1:0][2*NS-1:0] r_rt_n    [1:NS];
    logic [N_AXES-1:0][RW-1:0]   r_rt_rem  [1:NS];
    logic [N_AXES-1:0][NW-1:0]   r_rt_root [1:NS];

    for (genvar j = 0; j < NS; j++) begin : g_root
        t_side                       s_side;
        logic                        s_vld;
        logic [N_AXES-1:0][2*NS-1:0] s_n;
        logic [N_AXES-1:0][RW-1:0]   s_rem;
        logic [N_AXES-1:0][NW-1:0]   s_root;
        logic [N_AXES-1:0][RW-1:0]   n_rem;
        logic [N_AXES-1:0][NW-1:0]   n_root;
        logic [N_AXES-1:0][2*NS-1:0] n_n;

        if (j == 0) begin : g_first
            always_comb begin
                s_side = r_e;
                s_vld  = r_vld_e;
                for (int k = 0; k < N_AXES; k++) begin
                    s_n[k]    = (2*NS)'({r_rad[k], {FRAC_BITS{1'b0}}});
                    s_rem[k]  = '0;
                    s_root[k] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                s_side = r_rt_side[j];
                s_vld  = r_rt_vld[j];
                s_n    = r_rt_n[j];
                s_rem  = r_rt_rem[j];
                s_root = r_rt_root[j];
            end
        end

        always_comb begin
            for (int k = 0; k < N_AXES; k++) begin
                logic [RW-1:0] rem;
                logic [RW-1:0] trial;
                rem   = {s_rem[k][RW-3:0], s_n[k][2*NS-1 -: 2]};
                trial = {s_root[k], 2'b01};
                n_n[k] = s_n[k] << 2;
                if (rem >= trial) begin
                    n_rem[k]  = rem - trial;
                    n_root[k] = {s_root[k][NW-2:0], 1'b1};
                end else begin
                    n_rem[k]  = rem;
                    n_root[k] = {s_root[k][NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_vld[j+1] <= 1'b0;
            end else if (adv) begin
                r_rt_vld[j+1] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_rt_side[j+1] <= s_side;
                r_rt_n[j+1]    <= n_n;
                r_rt_rem[j+1]  <= n_rem;
                r_rt_root[j+1] <= n_root;
            end
        end
    end

    // final scaling and output register
    logic [N_AXES-1:0][FIELD_W-1:0] n_out;
    t_side                          fin;

    always_comb begin
        fin = r_rt_side[NS];
        for (int k = 0; k < N_AXES; k++) begin
            logic [2*NW-1:0]    prod;
            logic [NW+FIELD_W-1:0] pw;
            prod = fin.mag[k] * r_rt_root[NS][k];
            pw   = (NW+FIELD_W)'(prod >> FRAC_BITS);
            if (fin.bad) begin
                n_out[k] = '0;
            end else if (fin.neg[k]) begin
                n_out[k] = -pw[FIELD_W-1:0];
            end else begin
                n_out[k] = pw[FIELD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= r_rt_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_sphere_x  <= n_out[0];
            o_sphere_y  <= n_out[1];
            o_sphere_z  <= n_out[2];
            o_bad_input <= fin.bad;
        end
    end

endmodule

@@ rtl/core/cfsp_checker.sv @@
// port-level checks for the cube face to sphere point mapper
// depends on cfsp_pkg; bound to cube_face_to_sphere_point below
module cfsp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic signed [cfsp_pkg::FIELD_W-1:0] o_sphere_x,
    input logic signed [cfsp_pkg::FIELD_W-1:0] o_sphere_y,
    input logic signed [cfsp_pkg::FIELD_W-1:0] o_sphere_z,
    input logic                                o_bad_input
);
    import cfsp_pkg::*;

    // a rejected point carries zero coordinates
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_input) |-> (o_sphere_x == '0 && o_sphere_y == '0
                                      && o_sphere_z == '0))
        else $error("bad input with nonzero coordinates");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_sphere_x)
            && $stable(o_sphere_y) && $stable(o_sphere_z) && $stable(o_bad_input)))
        else $error("stalled result changed");

    // input side is stopped exactly while the output is stalled
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("ready does not follow output stall");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind cube_face_to_sphere_point cfsp_checker u_cfsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_sphere_x  (o_sphere_x),
    .o_sphere_y  (o_sphere_y),
    .o_sphere_z  (o_sphere_z),
    .o_bad_input (o_bad_input)
);
